// File: hw/rtl/source_text_tokenizer_assert.svh
// Assertion macros for the checker file of the source text tokenizer.
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH

// Implication in the same cycle, switched off while reset is high.
`define STT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication into the next cycle, checked during reset as well.
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/stt_pkg.sv
// Types, constants and lookup functions of the source text tokenizer.
package stt_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int LINE_BITS   = 24;
   localparam int LENGTH_BITS = 16;
   localparam int KW_COUNT    = 25;
   localparam int KW_MAXLEN   = 7;

   // Token kinds that the scanner names directly.
   localparam logic [6:0] K_NUM   = 7'd25;
   localparam logic [6:0] K_HEX   = 7'd26;
   localparam logic [6:0] K_BIN   = 7'd27;
   localparam logic [6:0] K_OCT   = 7'd28;
   localparam logic [6:0] K_STR   = 7'd29;
   localparam logic [6:0] K_CHR   = 7'd30;
   localparam logic [6:0] K_IDENT = 7'd31;
   localparam logic [6:0] K_PUNCT = 7'd32;
   localparam logic [6:0] K_EOF   = 7'd71;
   localparam logic [6:0] K_NONE  = 7'd0;

   // Error codes.
   localparam logic [2:0] E_NONE    = 3'd0;
   localparam logic [2:0] E_HEX     = 3'd1;
   localparam logic [2:0] E_BIN     = 3'd2;
   localparam logic [2:0] E_OCT     = 3'd3;
   localparam logic [2:0] E_STR     = 3'd4;
   localparam logic [2:0] E_CHR     = 3'd5;
   localparam logic [2:0] E_UNKNOWN = 3'd6;

   // Operator prefixes.
   localparam logic [3:0] P_LT  = 4'd11;
   localparam logic [3:0] P_GT  = 4'd12;
   localparam logic [3:0] P_SHL = 4'd13;
   localparam logic [3:0] P_LAST_SINGLE = 4'd12;

   typedef enum logic [3:0] {
      M_IDLE, M_WORD, M_ZERO, M_INT, M_FRAC, M_HEX0, M_HEX, M_BIN0, M_BIN,
      M_OCT0, M_OCT, M_STR, M_CHOPEN, M_CHESC, M_CHCLOSE, M_OP
   } mode_type;

   typedef struct packed {
      logic [7:0] text_byte;
   } req_type;

   typedef struct packed {
      logic [6:0]             token_kind;
      logic [OFFSET_BITS-1:0] token_offset;
      logic [LENGTH_BITS-1:0] token_length;
      logic [LINE_BITS-1:0]   token_line;
      logic [2:0]             error_code;
      logic                   last_of_run;
   } rsp_type;

   // Keywords, left aligned and padded with zero bytes.
   localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_COUNT] = '{
      {"void", 24'h0}, {"bool", 24'h0}, {"char", 24'h0}, {"const", 16'h0},
      {"case", 24'h0}, {"uchar", 16'h0}, {"ushort", 8'h0}, {"uint", 24'h0},
      {"ulong", 16'h0}, {"union", 16'h0}, {"short", 16'h0}, {"switch", 8'h0},
      {"struct", 8'h0}, {"int", 32'h0}, {"if", 40'h0}, {"float", 16'h0},
      {"for", 32'h0}, {"long", 24'h0}, {"double", 8'h0}, {"die", 32'h0},
      {"return", 8'h0}, {"typedef"}, {"enum", 24'h0}, {"else", 24'h0},
      {"while", 16'h0}
   };

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_xdigit(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   // Kind of a finished word: a keyword index, or identifier.
   function automatic logic [6:0] word_kind(input logic [8*KW_MAXLEN-1:0] w,
                                            input logic [3:0] wlen);
      logic [6:0] kind;
      kind = K_IDENT;
      for (int j = 0; j < KW_COUNT; j++) begin
         if (wlen <= 4'(KW_MAXLEN) && w == KW_TEXT[j]) begin
            kind = 7'(j);
         end
      end
      return kind;
   endfunction

   function automatic logic [7:0] op_char(input logic [3:0] pr);
      case (pr)
         4'd1:  return "=";
         4'd2:  return "+";
         4'd3:  return "-";
         4'd4:  return "*";
         4'd5:  return "/";
         4'd6:  return "%";
         4'd7:  return "&";
         4'd8:  return "|";
         4'd9:  return "^";
         4'd10: return "~";
         4'd11: return "<";
         4'd12: return ">";
         4'd13: return "<";
         4'd14: return ">";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [6:0] op_single(input logic [3:0] pr);
      case (pr)
         4'd1:  return 7'd39;
         4'd2:  return 7'd41;
         4'd3:  return 7'd44;
         4'd4:  return 7'd47;
         4'd5:  return 7'd49;
         4'd6:  return 7'd51;
         4'd7:  return 7'd53;
         4'd8:  return 7'd56;
         4'd9:  return 7'd59;
         4'd10: return 7'd61;
         4'd11: return 7'd63;
         4'd12: return 7'd67;
         4'd13: return 7'd65;
         4'd14: return 7'd69;
         default: return K_NONE;
      endcase
   endfunction

   function automatic logic [6:0] op_eq(input logic [3:0] pr);
      case (pr)
         4'd1:  return 7'd40;
         4'd2:  return 7'd43;
         4'd3:  return 7'd46;
         4'd4:  return 7'd48;
         4'd5:  return 7'd50;
         4'd6:  return 7'd52;
         4'd7:  return 7'd55;
         4'd8:  return 7'd58;
         4'd9:  return 7'd60;
         4'd10: return 7'd62;
         4'd11: return 7'd64;
         4'd12: return 7'd68;
         4'd13: return 7'd66;
         4'd14: return 7'd70;
         default: return K_NONE;
      endcase
   endfunction

   function automatic logic [6:0] op_double(input logic [3:0] pr);
      case (pr)
         4'd2:  return 7'd42;
         4'd3:  return 7'd45;
         4'd7:  return 7'd54;
         4'd8:  return 7'd57;
         default: return K_NONE;
      endcase
   endfunction

   // Punctuator index plus one, zero when the byte is none.
   function automatic logic [2:0] punct_code(input logic [7:0] c);
      case (c)
         ";":     return 3'd1;
         "(":     return 3'd2;
         ")":     return 3'd3;
         "[":     return 3'd4;
         "]":     return 3'd5;
         "{":     return 3'd6;
         "}":     return 3'd7;
         default: return 3'd0;
      endcase
   endfunction

endpackage

// File: hw/rtl/stt_stream_if.sv
// Valid/ready stream interface used by both channels of the tokenizer.
interface stt_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/source_text_tokenizer.sv
// Streaming maximal-munch tokenizer: source bytes in, tokens out.
//
//   channel  | dir | payload                                  | handshake
//   req_chan | in  | text_byte                                | valid/ready
//   rsp_chan | out | kind, offset, length, line, error, last  | valid/ready
//
// One byte is taken per cycle; its tokens are written into a four-entry result
// queue in the same cycle and leave one per cycle, so the two tokens of a byte
// leave one after the other. The byte is taken while two queue slots are free.
// Reset is synchronous and returns the scanner to the idle state at offset zero.
// A stall on the result side fills the queue and then holds off input.
module source_text_tokenizer (
   input logic clock,
   input logic reset,
   stt_stream_if.sink   req_chan,
   stt_stream_if.source rsp_chan
);
   import stt_pkg::*;

   localparam int LEN_CNT_BITS = LENGTH_BITS + 1;
   localparam logic [LEN_CNT_BITS-1:0] LEN_CAP = LEN_CNT_BITS'(1) << LENGTH_BITS;
   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

   // Scanner state.
   mode_type                  mode_ff, mode_in;
   logic [3:0]                prefix_ff, prefix_in;
   logic [OFFSET_BITS-1:0]    begin_ff, begin_in;
   logic [OFFSET_BITS-1:0]    pos_ff, pos_in;
   logic [LINE_BITS-1:0]      line_ff, line_in;
   logic                      halted_ff, halted_in;
   logic [LEN_CNT_BITS-1:0]   toklen_ff, toklen_in;
   logic [8*KW_MAXLEN-1:0]    wbuf_ff, wbuf_in;
   logic [3:0]                wlen_ff, wlen_in;

   // Result queue.
   rsp_type    queue_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] count_ff;

   logic       accept, pop;
   logic [7:0] b;
   rsp_type    res0, res1;
   logic [1:0] nres;

   logic                    rescan, pend_put, idle_put;
   logic [6:0]              pend_kind, idle_kind;
   logic [2:0]              pend_err, idle_err;
   logic                    pend_plus;
   logic                    idle_len1;
   logic [LEN_CNT_BITS-1:0] toklen_inc, pend_len_raw;
   logic [LENGTH_BITS-1:0]  pend_len;
   logic [2:0]              pc;

   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = rsp_chan.valid && rsp_chan.ready;
   assign b      = req_chan.payload.text_byte;
   assign req_chan.ready = (count_ff <= 3'd2);
   assign rsp_chan.valid = (count_ff != 3'd0);
   assign rsp_chan.payload = queue_ff[rd_ff];

   assign toklen_inc = (toklen_ff == LEN_CAP) ? toklen_ff : toklen_ff + 1'b1;
   assign pc = punct_code(b);

   // Scan one byte: finish or extend a pending token, then scan afresh if needed.
   always_comb begin
      mode_in   = mode_ff;
      prefix_in = prefix_ff;
      begin_in  = begin_ff;
      pos_in    = pos_ff;
      line_in   = line_ff;
      halted_in = halted_ff;
      toklen_in = toklen_ff;
      wbuf_in   = wbuf_ff;
      wlen_in   = wlen_ff;
      rescan    = 1'b0;
      pend_put  = 1'b0;
      pend_kind = K_NONE;
      pend_err  = E_NONE;
      pend_plus = 1'b0;
      idle_put  = 1'b0;
      idle_kind = K_NONE;
      idle_err  = E_NONE;
      idle_len1 = 1'b0;

      if (!halted_ff) begin
         pos_in = pos_ff + 1'b1;
         // Pending token: extend, complete, finish or fail.
         case (mode_ff)
            M_IDLE: rescan = 1'b1;
            M_WORD: begin
               if (is_word(b)) begin
                  for (int k = 0; k < KW_MAXLEN; k++) begin
                     if (wlen_ff == 4'(k)) begin
                        wbuf_in[8*(KW_MAXLEN-k)-1 -: 8] = b;
                     end
                  end
                  wlen_in = (wlen_ff > 4'(KW_MAXLEN)) ? wlen_ff : wlen_ff + 1'b1;
               end else begin
                  pend_put  = 1'b1;
                  pend_kind = word_kind(wbuf_ff, wlen_ff);
               end
            end
            M_ZERO, M_INT: begin
               if (mode_ff == M_ZERO && b == "x") begin
                  mode_in = M_HEX0;
               end else if (mode_ff == M_ZERO && b == "b") begin
                  mode_in = M_BIN0;
               end else if (mode_ff == M_ZERO && b == "o") begin
                  mode_in = M_OCT0;
               end else if (is_digit(b)) begin
                  mode_in = M_INT;
               end else if (b == ".") begin
                  mode_in = M_FRAC;
               end else begin
                  pend_put  = 1'b1;
                  pend_kind = K_NUM;
               end
            end
            M_FRAC: begin
               if (!is_digit(b)) begin
                  pend_put  = 1'b1;
                  pend_kind = K_NUM;
               end
            end
            M_HEX0: begin
               if (is_xdigit(b)) begin
                  mode_in = M_HEX;
               end else begin
                  pend_put = 1'b1;
                  pend_err = E_HEX;
               end
            end
            M_HEX: begin
               if (!is_xdigit(b)) begin
                  pend_put  = 1'b1;
                  pend_kind = K_HEX;
               end
            end
            M_BIN0: begin
               if (b == "0" || b == "1") begin
                  mode_in = M_BIN;
               end else begin
                  pend_put = 1'b1;
                  pend_err = E_BIN;
               end
            end
            M_BIN: begin
               if (!(b == "0" || b == "1")) begin
                  pend_put  = 1'b1;
                  pend_kind = K_BIN;
               end
            end
            M_OCT0: begin
               if (b >= "0" && b <= "7") begin
                  mode_in = M_OCT;
               end else begin
                  pend_put = 1'b1;
                  pend_err = E_OCT;
               end
            end
            M_OCT: begin
               if (!(b >= "0" && b <= "7")) begin
                  pend_put  = 1'b1;
                  pend_kind = K_OCT;
               end
            end
            M_STR: begin
               if (b == "\"") begin
                  pend_put  = 1'b1;
                  pend_kind = K_STR;
                  pend_plus = 1'b1;
               end else if (b == 8'h00) begin
                  pend_put = 1'b1;
                  pend_err = E_STR;
               end
            end
            M_CHOPEN: begin
               if (b == 8'h00) begin
                  pend_put = 1'b1;
                  pend_err = E_CHR;
               end else begin
                  mode_in = (b == "\\") ? M_CHESC : M_CHCLOSE;
               end
            end
            M_CHESC: begin
               if (b == 8'h00) begin
                  pend_put = 1'b1;
                  pend_err = E_CHR;
               end else begin
                  mode_in = M_CHCLOSE;
               end
            end
            M_CHCLOSE: begin
               pend_put = 1'b1;
               if (b == "'") begin
                  pend_kind = K_CHR;
                  pend_plus = 1'b1;
               end else begin
                  pend_err = E_CHR;
               end
            end
            M_OP: begin
               if (b == "=") begin
                  pend_put  = 1'b1;
                  pend_kind = op_eq(prefix_ff);
                  pend_plus = 1'b1;
               end else if (b == op_char(prefix_ff) &&
                            (prefix_ff == P_LT || prefix_ff == P_GT)) begin
                  prefix_in = prefix_ff + 4'd2;
               end else if (b == op_char(prefix_ff) && op_double(prefix_ff) != K_NONE) begin
                  pend_put  = 1'b1;
                  pend_kind = op_double(prefix_ff);
                  pend_plus = 1'b1;
               end else begin
                  pend_put  = 1'b1;
                  pend_kind = op_single(prefix_ff);
               end
            end
            default: rescan = 1'b1;
         endcase

         // Errors always count the revealing byte; a finish without a closing byte ends before it.
         if (pend_err != E_NONE) begin
            pend_plus = 1'b1;
            pend_kind = K_NONE;
            halted_in = 1'b1;
            mode_in   = M_IDLE;
         end else if (pend_put) begin
            mode_in = M_IDLE;
            rescan  = !pend_plus;
         end else if (!rescan) begin
            toklen_in = toklen_inc;
         end

         // Scan afresh between tokens.
         if (rescan) begin
            mode_in = M_IDLE;
            if (b == " " || b == "\t") begin
               mode_in = M_IDLE;
            end else if (b == "\n") begin
               if (line_ff != LINE_MAX) begin
                  line_in = line_ff + 1'b1;
               end
            end else if (b == 8'h00) begin
               idle_put  = 1'b1;
               idle_kind = K_EOF;
            end else begin
               begin_in  = pos_ff;
               toklen_in = LEN_CNT_BITS'(1);
               if (is_alpha(b)) begin
                  mode_in = M_WORD;
                  wbuf_in = {b, {(8*(KW_MAXLEN-1)){1'b0}}};
                  wlen_in = 4'd1;
               end else if (is_digit(b)) begin
                  mode_in = (b == "0") ? M_ZERO : M_INT;
               end else if (b == "\"") begin
                  mode_in = M_STR;
               end else if (b == "'") begin
                  mode_in = M_CHOPEN;
               end else if (pc != 3'd0) begin
                  idle_put  = 1'b1;
                  idle_kind = K_PUNCT + 7'(pc) - 7'd1;
                  idle_len1 = 1'b1;
               end else begin
                  idle_put  = 1'b1;
                  idle_len1 = 1'b1;
                  idle_err  = E_UNKNOWN;
                  halted_in = 1'b1;
                  for (int p = P_LAST_SINGLE; p >= 1; p--) begin
                     if (b == op_char(4'(p))) begin
                        idle_put  = 1'b0;
                        idle_len1 = 1'b0;
                        idle_err  = E_NONE;
                        halted_in = 1'b0;
                        mode_in   = M_OP;
                        prefix_in = 4'(p);
                     end
                  end
               end
            end
         end
      end
   end

   // Saturated length of a pending token.
   always_comb begin
      pend_len_raw = pend_plus ? toklen_inc : toklen_ff;
      pend_len = (pend_len_raw == LEN_CAP) ? '1 : pend_len_raw[LENGTH_BITS-1:0];
   end

   // Arrange up to two results in order.
   always_comb begin
      rsp_type pr_item, id_item;
      pr_item.token_kind   = pend_kind;
      pr_item.token_offset = begin_ff;
      pr_item.token_length = pend_len;
      pr_item.token_line   = line_ff;
      pr_item.error_code   = pend_err;
      pr_item.last_of_run  = !idle_put;
      id_item.token_kind   = idle_kind;
      id_item.token_offset = pos_ff;
      id_item.token_length = LENGTH_BITS'(idle_len1);
      id_item.token_line   = line_ff;
      id_item.error_code   = idle_err;
      id_item.last_of_run  = 1'b1;
      res0 = pend_put ? pr_item : id_item;
      res1 = id_item;
      nres = 2'(pend_put) + 2'(idle_put);
   end

   // Scanner registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         prefix_ff <= '0;
         begin_ff  <= '0;
         pos_ff    <= '0;
         line_ff   <= '0;
         halted_ff <= 1'b0;
         toklen_ff <= '0;
         wlen_ff   <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         prefix_ff <= prefix_in;
         begin_ff  <= begin_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         halted_ff <= halted_in;
         toklen_ff <= toklen_in;
         wlen_ff   <= wlen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wbuf_ff <= wbuf_in;
      end
   end

   // Result queue pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            wr_ff <= wr_ff + nres;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + (accept ? 3'(nres) : 3'd0) - 3'(pop);
      end
   end

   // Result queue storage.
   always_ff @(posedge clock) begin
      if (accept && nres != 2'd0) begin
         queue_ff[wr_ff] <= res0;
      end
      if (accept && nres == 2'd2) begin
         queue_ff[wr_ff + 1'b1] <= res1;
      end
   end

endmodule

// File: hw/rtl/stt_checker.sv
// Port-level checks of the tokenizer and the bind that attaches them.
`include "source_text_tokenizer_assert.svh"

module stt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [6:0]                     token_kind,
   input logic [stt_pkg::LENGTH_BITS-1:0] token_length,
   input logic [2:0]                     error_code,
   input logic                           last_of_run
);
   import stt_pkg::*;

   // No result is offered straight after reset.
   `STT_ASSERT_NEXT(a_reset_empty, reset, !rsp_valid, "result offered after reset")

   // An error ends the run of results for its byte.
   `STT_ASSERT_SAME(a_error_last, rsp_valid && error_code != E_NONE, last_of_run, "error not last")

   // An end-of-input item has no length.
   `STT_ASSERT_SAME(a_eof_len, rsp_valid && error_code == E_NONE && token_kind == K_EOF, token_length == '0, "EOF with length")

   // A stalled item stays offered.
   `STT_ASSERT_NEXT(a_stall_hold, !reset && rsp_valid && !rsp_ready, reset || rsp_valid, "stalled item dropped")

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .token_kind   (rsp_chan.payload.token_kind),
   .token_length (rsp_chan.payload.token_length),
   .error_code   (rsp_chan.payload.error_code),
   .last_of_run  (rsp_chan.payload.last_of_run)
);
